// ----- rtl/bsb_pkg.sv -----
// Shared types and constants for the B-spline basis evaluation unit.
// Used by bsb_front, bsb_queue, bsb_core and the top level.
package bsb_pkg;

  localparam int FUNC_W = 1;
  localparam int KIDX_W = 6;
  localparam int VAL_W = 32;
  localparam int BIDX_W = 6;
  localparam int BVAL_W = 17;
  localparam int STAT_W = 2;

  // Table size, highest degree and fraction bits of the fixed-point values
  localparam int MAX_KNOTS = 64;
  localparam int MAX_DEGREE = 7;
  localparam int FRAC_BITS = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_CLAMP = 2'd1;
  localparam logic [STAT_W-1:0] ST_ZDEN = 2'd2;

  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_KNOTS = 1'b1;

  // One input word after decoding
  typedef struct packed {
    logic              func;
    logic [KIDX_W-1:0] kidx;
    logic [VAL_W-1:0]  value;
  } item_t;

  // One result word
  typedef struct packed {
    logic [BIDX_W-1:0] bidx;
    logic [BVAL_W-1:0] bval;
    logic              last;
    logic [STAT_W-1:0] status;
  } res_t;

endpackage

// ----- rtl/bsb_queue.sv -----
// Small FIFO that separates the input front end from the evaluation core.
// Depends on bsb_pkg for the item type.
module bsb_queue
  import bsb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/bsb_front.sv -----
// Input front end: unpacks stream words and pushes them into the queue.
// Depends on bsb_pkg.
module bsb_front
  import bsb_pkg::*;
(
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [39:0]      in_tdata,
  input  logic             in_tuser,
  input  logic             q_full,
  output logic             q_wr,
  output item_t            q_data
);

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign q_wr = in_tvalid && !q_full;
  assign q_data.func = in_tuser;
  assign q_data.kidx = in_tdata[KIDX_W-1:0];
  assign q_data.value = in_tdata[KIDX_W +: VAL_W];

endmodule

// ----- rtl/bsb_core.sv -----
// Evaluation core: knot memory, span search, Cox-de Boor triangle with a
// shared restoring divider, result output register. Depends on bsb_pkg.
module bsb_core
  import bsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  degree,
  input  logic [6:0]  knot_count,
  input  logic        q_empty,
  input  item_t       q_data,
  output logic        q_rd,
  output logic        out_valid,
  input  logic        out_ready,
  output res_t        out_res
);

  localparam int KAW = $clog2(MAX_KNOTS);
  localparam int NW = KAW + 1;
  localparam int DW = $clog2(MAX_DEGREE + 1) + 1;
  localparam int NE = MAX_DEGREE + 1;
  localparam int EW = $clog2(NE);
  localparam int DIST_W = VAL_W + 1;
  localparam int PW = 64;
  localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] QLIM = PW'(1) << 40;

  typedef enum logic [3:0] {
    S_IDLE, S_K0, S_KN, S_SRCH, S_SRCHW, S_SPAN, S_LVL_A, S_LVL_B,
    S_DEN, S_MUL, S_DIV, S_UPD, S_OUT
  } state_t;

  state_t state_r;
  logic [VAL_W-1:0] knot_mem [MAX_KNOTS];
  logic [KAW-1:0] raddr;
  logic [VAL_W-1:0] rdata_r;

  logic signed [VAL_W-1:0] x_r;
  logic [NW-1:0] n_r, lo_r, hi_r, span_r;
  logic [DW-1:0] d_r, j_r, r_r, k_r;
  logic [STAT_W-1:0] st_r;
  logic [BVAL_W-1:0] nb_r [NE];
  logic signed [DIST_W-1:0] left_r [NE];
  logic signed [DIST_W-1:0] right_r [NE];
  logic signed [PW-1:0] saved_r;
  logic signed [DIST_W:0] den_r;
  logic [PW-1:0] num_r, rem_r, quo_r, dmag_r;
  logic [6:0] bit_r;
  logic neg_r;
  logic signed [VAL_W-1:0] kv;

  assign kv = $signed(rdata_r);
  assign q_rd = (state_r == S_IDLE) && !q_empty;

  // Knot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (q_rd && q_data.func == FUNC_LOAD && int'(q_data.kidx) < MAX_KNOTS) begin
      knot_mem[KAW'(q_data.kidx)] <= q_data.value;
    end
    rdata_r <= knot_mem[raddr];
  end

  logic [NW-1:0] mid;
  logic [NW-1:0] span_min, span_top;
  assign mid = NW'((lo_r + hi_r) >> 1);
  assign span_min = (lo_r < NW'(d_r)) ? NW'(d_r) : lo_r;
  assign span_top = n_r - NW'(d_r) - NW'(2);

  // Select read address for the next step
  always_comb begin
    raddr = '0;
    unique case (state_r)
      S_IDLE: raddr = '0;
      S_K0: raddr = KAW'(n_r - 1'b1);
      S_KN, S_SRCHW, S_SRCH: raddr = KAW'(mid);
      S_SPAN, S_UPD: raddr = KAW'(span_r + NW'(1) - NW'(j_r));
      S_LVL_A: raddr = KAW'(span_r + NW'(j_r));
      default: raddr = '0;
    endcase
  end

  logic [NW-1:0] dn;
  logic signed [PW-1:0] qs;
  logic signed [DIST_W:0] den_c;
  logic [PW-1:0] trial, quo_sh;
  logic ge;
  logic [DIST_W-1:0] amag;
  logic [DIST_W+BVAL_W-1:0] prod;
  logic emit;

  assign dn = NW'(degree < 3'(MAX_DEGREE) ? degree : 3'(MAX_DEGREE));
  assign den_c = (DIST_W+1)'(right_r[EW'(r_r + 1'b1)]) + (DIST_W+1)'(left_r[EW'(j_r - r_r)]);
  assign trial = {rem_r[PW-2:0], num_r[bit_r[5:0]]};
  assign ge = (trial >= dmag_r);
  assign quo_sh = {quo_r[PW-2:0], ge};
  assign qs = neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign amag = (right_r[EW'(r_r + 1'b1)] < 0) ? DIST_W'(-right_r[EW'(r_r + 1'b1)])
                                               : DIST_W'(right_r[EW'(r_r + 1'b1)]);
  assign prod = amag * nb_r[EW'(r_r)];
  assign emit = (state_r == S_OUT) && k_r[DW-1] && (!out_valid || out_ready);

  function automatic logic [BVAL_W-1:0] sat1(input logic signed [PW-1:0] v);
    if (v < 0) return '0;
    if (v > $signed(ONE)) return BVAL_W'(ONE);
    return BVAL_W'(v);
  endfunction

  // Sequencer: search, triangle, output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_rd && q_data.func == FUNC_EVAL) begin
            x_r <= $signed(q_data.value);
            n_r <= NW'(knot_count < 7'(MAX_KNOTS) ? knot_count : 7'(MAX_KNOTS));
            d_r <= DW'(dn);
            st_r <= ST_OK;
            if ((knot_count < 7'(MAX_KNOTS) ? 7'(knot_count) : 7'(MAX_KNOTS)) >= 7'(dn) + 7'd2)
              state_r <= S_K0;
          end
        end
        S_K0: begin
          if (x_r < kv) st_r <= ST_CLAMP;
          lo_r <= '0;
          hi_r <= n_r - 1'b1;
          state_r <= S_KN;
        end
        S_KN: begin
          if (x_r > kv) st_r <= ST_CLAMP;
          state_r <= S_SRCHW;
        end
        S_SRCHW: begin
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (hi_r - lo_r > NW'(1)) begin
            if (x_r < kv) hi_r <= mid; else lo_r <= mid;
            state_r <= S_SRCHW;
          end else begin
            span_r <= (span_min > span_top) ? span_top : span_min;
            for (int i = 0; i < NE; i++) begin
              nb_r[i] <= (i == 0) ? BVAL_W'(ONE) : '0;
              left_r[i] <= '0;
              right_r[i] <= '0;
            end
            j_r <= DW'(1);
            k_r <= '0;
            state_r <= (d_r == '0) ? S_OUT : S_SPAN;
          end
        end
        S_SPAN: state_r <= S_LVL_A;
        S_LVL_A: begin
          left_r[EW'(j_r)] <= DIST_W'(x_r) - DIST_W'(kv);
          state_r <= S_LVL_B;
        end
        S_LVL_B: begin
          right_r[EW'(j_r)] <= DIST_W'(kv) - DIST_W'(x_r);
          saved_r <= '0;
          r_r <= '0;
          state_r <= S_DEN;
        end
        S_DEN: begin
          den_r <= den_c;
          neg_r <= (right_r[EW'(r_r + 1'b1)] < 0) != (den_c < 0);
          dmag_r <= PW'(den_c < 0 ? -den_c : den_c);
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r <= PW'(prod);
          rem_r <= '0;
          quo_r <= '0;
          bit_r <= 7'(PW - 1);
          state_r <= (den_r == '0) ? S_UPD : S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? trial - dmag_r : trial;
          // limit the quotient magnitude on the final bit
          quo_r <= (bit_r == '0 && quo_sh > QLIM) ? QLIM : quo_sh;
          if (bit_r == '0) begin
            state_r <= S_UPD;
          end else begin
            bit_r <= bit_r - 1'b1;
          end
        end
        S_UPD: begin
          if (den_r == '0) begin
            st_r <= ST_ZDEN;
            nb_r[EW'(r_r)] <= sat1(saved_r);
            saved_r <= '0;
          end else begin
            nb_r[EW'(r_r)] <= sat1(saved_r + qs);
            saved_r <= $signed(PW'(nb_r[EW'(r_r)])) - qs;
          end
          if (r_r + 1'b1 == j_r) begin
            state_r <= S_OUT;
          end else begin
            r_r <= r_r + 1'b1;
            state_r <= S_DEN;
          end
        end
        S_OUT: begin
          if (!k_r[DW-1]) begin
            // close the level: N[j] = sat(saved)
            if (d_r != '0) nb_r[EW'(j_r)] <= sat1(saved_r);
            if (j_r == d_r || d_r == '0) begin
              k_r <= DW'(1) << (DW - 1);
            end else begin
              j_r <= j_r + 1'b1;
              state_r <= S_SPAN;
            end
          end else if (emit) begin
            out_res.bidx <= BIDX_W'(span_r - NW'(d_r) + NW'(k_r[DW-2:0]));
            out_res.bval <= nb_r[EW'(k_r[DW-2:0])];
            out_res.last <= (k_r[DW-2:0] == d_r[DW-2:0]);
            out_res.status <= st_r;
            if (k_r[DW-2:0] == d_r[DW-2:0]) state_r <= S_IDLE;
            k_r <= {1'b1, k_r[DW-2:0] + 1'b1};
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // Load a new result word or drop the one taken
      if (emit) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/bspline_basis_eval_unit.sv -----
// B-spline basis evaluation unit (Cox-de Boor).
// Channels: in_* stream carries load and evaluate words; out_* stream
// returns degree+1 basis words per evaluate word, tlast on the final one,
// or none if knot_count is below degree+2. cfg_* writes degree (index 0)
// and knot_count (index 1); the user must write them only while idle,
// which the block does not enforce. A two-entry queue decouples input
// from the core, so words are taken while the core works; load words go
// to the knot table from idle. Evaluate words run an end-knot clamp check,
// a binary span search and, per triangle step, the denominator, the
// multiply, the shared restoring divider (skipped when the denominator is
// zero) and the update; d(d+1)/2 steps for degree d, then d+1 output
// words, one per cycle while out_tready is high. A stalled receiver holds
// the output register and the core waits; the queue keeps accepting until
// full. Reset (rst_n, synchronous) empties the queue and idles the core;
// degree returns to 3, knot_count to 0. The knot table is undefined until
// loaded. Throughput is set by the divider loop, one quotient bit per cycle.
module bspline_basis_eval_unit
  import bsb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // knot_index[5:0], value[37:6], zero fill
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // basis_index[5:0], basis_value[22:6], zero fill
  output logic        out_tlast,
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata
);

  logic [2:0] degree_r;
  logic [6:0] knots_r;
  logic q_full, q_wr, q_rd, q_empty;
  item_t q_in, q_out;
  res_t res;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= 3'd3;
      knots_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEGREE) degree_r <= cfg_wdata[2:0];
      else knots_r <= cfg_wdata;
    end
  end

  bsb_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .q_full(q_full), .q_wr(q_wr), .q_data(q_in)
  );

  bsb_queue #(.DEPTH(2)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(q_wr), .wr_data(q_in), .full(q_full),
    .rd_en(q_rd), .rd_data(q_out), .empty(q_empty)
  );

  bsb_core u_core (
    .clk(clk), .rst_n(rst_n), .degree(degree_r), .knot_count(knots_r),
    .q_empty(q_empty), .q_data(q_out), .q_rd(q_rd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {1'b0, res.bval, res.bidx};
  assign out_tlast = res.last;
  assign out_tuser = res.status;

endmodule
